[rtl/scr_pkg.sv]
// Shared widths, side-data structures and the saturation helper for the
// sphere collision pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scr_pkg;

   localparam int PosW      = 32;
   localparam int RadW      = 24;
   localparam int MassW     = 16;
   localparam int FlagW     = 2;
   localparam int FlagEnable = 0;
   localparam int FlagSolid  = 1;
   localparam int SumW      = RadW + 1;
   localparam int DiffW     = PosW + 1;
   localparam int SqW       = 2 * SumW;
   localparam int SqSumW    = SqW + 2;
   localparam int UnitShift = 30;
   localparam int QuoW      = UnitShift + 1;
   localparam int DivW      = SumW;
   localparam int NumW      = QuoW + DivW;
   localparam int ProdW     = SumW + MassW;
   localparam int TotW      = MassW + 1;
   localparam int StepW     = QuoW + SumW;
   localparam int WideW     = PosW + 2;

   typedef logic signed [PosW-1:0] pos_type;

   typedef struct packed {
      pos_type [2:0]             first_pos;
      pos_type [2:0]             second_pos;
      logic [2:0]                neg;
      logic [2:0][SumW-1:0]      mag;
      logic [SumW-1:0]           rsum;
      logic [MassW-1:0]          first_mass;
      logic [MassW-1:0]          second_mass;
      logic                      hit;
      logic                      stop;
      logic                      move;
   } root_side_type;

   typedef struct packed {
      pos_type [2:0]             first_pos;
      pos_type [2:0]             second_pos;
      logic [2:0]                neg;
      logic                      hit;
      logic                      stop;
      logic                      move;
      logic                      zero_total;
   } quo_side_type;

   function automatic pos_type sat_pos(input logic signed [WideW-1:0] v);
      logic signed [WideW-1:0] hi;
      logic signed [WideW-1:0] lo;
      hi = {3'b000, {(PosW-1){1'b1}}};
      lo = {3'b111, {(PosW-1){1'b0}}};
      if (v > hi) begin
         return hi[PosW-1:0];
      end else if (v < lo) begin
         return lo[PosW-1:0];
      end else begin
         return v[PosW-1:0];
      end
   endfunction

endpackage
`default_nettype wire

[rtl/scr_isqrt_pipe.sv]
// Pipelined integer square root, one root bit resolved per register stage.
// Carries an opaque side word alongside; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scr_isqrt_pipe #(
   parameter int RootW = 25,
   parameter int SW    = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [2*RootW-1:0]   in_radicand,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [RootW-1:0]     out_root,
   output logic [SW-1:0]        out_side
);
   localparam int RemW = 2 * RootW + 1;

   logic [RootW:0]             valid_chain;
   logic [RootW:0][RemW-1:0]   rem_chain;
   logic [RootW:0][RootW-1:0]  root_chain;
   logic [RootW:0][SW-1:0]     side_chain;

   assign valid_chain[0] = in_valid;
   assign rem_chain[0]   = RemW'(in_radicand);
   assign root_chain[0]  = '0;
   assign side_chain[0]  = in_side;

   for (genvar s = 0; s < RootW; s++) begin : g_stage
      localparam int Bit = RootW - 1 - s;
      logic [RemW-1:0]  trial;
      logic [RemW-1:0]  rem_in;
      logic [RemW-1:0]  rem_ff;
      logic [RootW-1:0] root_in;
      logic [RootW-1:0] root_ff;
      logic [SW-1:0]    side_ff;
      logic             valid_ff;

      always_comb begin
         trial = (RemW'(root_chain[s]) << (Bit + 1)) + (RemW'(1) << (2 * Bit));
         if (rem_chain[s] >= trial) begin
            rem_in  = rem_chain[s] - trial;
            root_in = root_chain[s] | (RootW'(1) << Bit);
         end else begin
            rem_in  = rem_chain[s];
            root_in = root_chain[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_chain[s];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_chain[s];
         end
      end

      assign valid_chain[s+1] = valid_ff;
      assign rem_chain[s+1]   = rem_ff;
      assign root_chain[s+1]  = root_ff;
      assign side_chain[s+1]  = side_ff;
   end

   assign out_valid = valid_chain[RootW];
   assign out_root  = root_chain[RootW];
   assign out_side  = side_chain[RootW];

endmodule
`default_nettype wire

[rtl/scr_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// The dividend must be below divisor times two to the QW; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scr_div_pipe #(
   parameter int QW = 31,
   parameter int DW = 25,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [QW+DW-1:0]     in_dividend,
   input  logic [DW-1:0]        in_divisor,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [QW-1:0]        out_quotient,
   output logic [SW-1:0]        out_side
);
   localparam int RemW = QW + DW;

   logic [QW:0]            valid_chain;
   logic [QW:0][RemW-1:0]  rem_chain;
   logic [QW:0][DW-1:0]    den_chain;
   logic [QW:0][QW-1:0]    quo_chain;
   logic [QW:0][SW-1:0]    side_chain;

   assign valid_chain[0] = in_valid;
   assign rem_chain[0]   = in_dividend;
   assign den_chain[0]   = in_divisor;
   assign quo_chain[0]   = '0;
   assign side_chain[0]  = in_side;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int Bit = QW - 1 - s;
      logic [RemW-1:0] trial;
      logic [RemW-1:0] rem_in;
      logic [RemW-1:0] rem_ff;
      logic [QW-1:0]   quo_in;
      logic [QW-1:0]   quo_ff;
      logic [DW-1:0]   den_ff;
      logic [SW-1:0]   side_ff;
      logic            valid_ff;

      always_comb begin
         trial = RemW'(den_chain[s]) << Bit;
         if (rem_chain[s] >= trial) begin
            rem_in = rem_chain[s] - trial;
            quo_in = quo_chain[s] | (QW'(1) << Bit);
         end else begin
            rem_in = rem_chain[s];
            quo_in = quo_chain[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_chain[s];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            den_ff  <= den_chain[s];
            side_ff <= side_chain[s];
         end
      end

      assign valid_chain[s+1] = valid_ff;
      assign rem_chain[s+1]   = rem_ff;
      assign den_chain[s+1]   = den_ff;
      assign quo_chain[s+1]   = quo_ff;
      assign side_chain[s+1]  = side_ff;
   end

   assign out_valid    = valid_chain[QW];
   assign out_quotient = quo_chain[QW];
   assign out_side     = side_chain[QW];

endmodule
`default_nettype wire

[rtl/sphere_collision_resolve_top.sv]
// Sphere-sphere collision test and mass-weighted separation, top level.
// Uses scr_pkg, scr_isqrt_pipe and scr_div_pipe.
//
// One body pair enters as a word on the req_ channel (valid/ready) and one
// result word leaves on the rsp_ channel for every pair, in order.
// The pipeline takes a new pair in every cycle that it advances; the
// sustained rate is one word per cycle while rsp_ready is high. A pair
// passes four front stages (difference, magnitude and range test,
// squares, sum and hit test), 25 square-root stages, one overlap and
// mass-product stage, 31 divider stages that form the unit vector and
// the mass shares in parallel, one multiply stage and the saturating output
// register. The 31 quotient bits of the unit-vector divider set the depth.
// The whole pipeline advances together; when the receiver holds rsp_ready
// low with a result waiting, every stage holds and req_ready drops, so no
// word is lost or repeated. Bubbles move forward whenever the output
// register is empty or is being taken.
// A synchronous reset clears all valid bits; the block has no other state.
`timescale 1ns / 1ps
`default_nettype none
module sphere_collision_resolve_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [31:0]           req_first_x,
   input  logic signed [31:0]           req_first_y,
   input  logic signed [31:0]           req_first_z,
   input  logic signed [31:0]           req_second_x,
   input  logic signed [31:0]           req_second_y,
   input  logic signed [31:0]           req_second_z,
   input  logic [23:0]                  req_first_radius,
   input  logic [23:0]                  req_second_radius,
   input  logic [15:0]                  req_first_mass,
   input  logic [15:0]                  req_second_mass,
   input  logic [1:0]                   req_first_flags,
   input  logic [1:0]                   req_second_flags,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic                         rsp_stop_both,
   output logic signed [31:0]           rsp_new_first_x,
   output logic signed [31:0]           rsp_new_first_y,
   output logic signed [31:0]           rsp_new_first_z,
   output logic signed [31:0]           rsp_new_second_x,
   output logic signed [31:0]           rsp_new_second_y,
   output logic signed [31:0]           rsp_new_second_z
);
   localparam int PosW   = scr_pkg::PosW;
   localparam int SumW   = scr_pkg::SumW;
   localparam int DiffW  = scr_pkg::DiffW;
   localparam int SqW    = scr_pkg::SqW;
   localparam int SqSumW = scr_pkg::SqSumW;
   localparam int MassW  = scr_pkg::MassW;
   localparam int QuoW   = scr_pkg::QuoW;
   localparam int DivW   = scr_pkg::DivW;
   localparam int NumW   = scr_pkg::NumW;
   localparam int ProdW  = scr_pkg::ProdW;
   localparam int TotW   = scr_pkg::TotW;
   localparam int StepW  = scr_pkg::StepW;
   localparam int WideW  = scr_pkg::WideW;
   localparam int UnitShift = scr_pkg::UnitShift;
   localparam int RootSideW = $bits(scr_pkg::root_side_type);
   localparam int QuoSideW  = $bits(scr_pkg::quo_side_type);

   logic adv;
   logic out_valid_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: per-axis differences.
   logic                           s1_valid_ff;
   scr_pkg::pos_type [2:0]         in_first;
   scr_pkg::pos_type [2:0]         in_second;
   scr_pkg::pos_type [2:0]         s1_first_ff;
   scr_pkg::pos_type [2:0]         s1_second_ff;
   logic [2:0][DiffW-1:0]          s1_diff_in;
   logic [2:0][DiffW-1:0]          s1_diff_ff;
   logic [SumW-1:0]                s1_rsum_ff;
   logic [MassW-1:0]               s1_m1_ff;
   logic [MassW-1:0]               s1_m2_ff;
   logic                           s1_enable_ff;
   logic                           s1_solid_ff;

   assign in_first  = {req_first_z, req_first_y, req_first_x};
   assign in_second = {req_second_z, req_second_y, req_second_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_diff_in[k] = {in_first[k][PosW-1], in_first[k]}
                       - {in_second[k][PosW-1], in_second[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         s1_first_ff  <= in_first;
         s1_second_ff <= in_second;
         s1_diff_ff   <= s1_diff_in;
         s1_rsum_ff   <= SumW'(req_first_radius) + SumW'(req_second_radius);
         s1_m1_ff     <= req_first_mass;
         s1_m2_ff     <= req_second_mass;
         s1_enable_ff <= req_first_flags[scr_pkg::FlagEnable]
                         & req_second_flags[scr_pkg::FlagEnable];
         s1_solid_ff  <= req_first_flags[scr_pkg::FlagSolid]
                         & req_second_flags[scr_pkg::FlagSolid];
      end
   end

   // Stage 2: magnitudes, box test and squared radius sum.
   logic                           s2_valid_ff;
   logic [2:0][DiffW-1:0]          s2_abs;
   logic                           s2_near_in;
   logic                           s2_near_ff;
   logic [2:0][SumW-1:0]           s2_mag_ff;
   logic [2:0]                     s2_neg_ff;
   logic [SqW-1:0]                 s2_rr_ff;
   scr_pkg::pos_type [2:0]         s2_first_ff;
   scr_pkg::pos_type [2:0]         s2_second_ff;
   logic [SumW-1:0]                s2_rsum_ff;
   logic [MassW-1:0]               s2_m1_ff;
   logic [MassW-1:0]               s2_m2_ff;
   logic                           s2_solid_ff;

   always_comb begin
      s2_near_in = s1_enable_ff;
      for (int k = 0; k < 3; k++) begin
         s2_abs[k] = s1_diff_ff[k][DiffW-1] ? (DiffW'(0) - s1_diff_ff[k]) : s1_diff_ff[k];
         if (!(s2_abs[k] < DiffW'(s1_rsum_ff))) begin
            s2_near_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_near_ff <= s2_near_in;
         for (int k = 0; k < 3; k++) begin
            s2_mag_ff[k] <= s2_abs[k][SumW-1:0];
            s2_neg_ff[k] <= s1_diff_ff[k][DiffW-1];
         end
         s2_rr_ff     <= SqW'(s1_rsum_ff) * SqW'(s1_rsum_ff);
         s2_first_ff  <= s1_first_ff;
         s2_second_ff <= s1_second_ff;
         s2_rsum_ff   <= s1_rsum_ff;
         s2_m1_ff     <= s1_m1_ff;
         s2_m2_ff     <= s1_m2_ff;
         s2_solid_ff  <= s1_solid_ff;
      end
   end

   // Stage 3: squares.
   logic                           s3_valid_ff;
   logic [2:0][SqW-1:0]            s3_sq_ff;
   logic                           s3_near_ff;
   logic [2:0][SumW-1:0]           s3_mag_ff;
   logic [2:0]                     s3_neg_ff;
   logic [SqW-1:0]                 s3_rr_ff;
   scr_pkg::pos_type [2:0]         s3_first_ff;
   scr_pkg::pos_type [2:0]         s3_second_ff;
   logic [SumW-1:0]                s3_rsum_ff;
   logic [MassW-1:0]               s3_m1_ff;
   logic [MassW-1:0]               s3_m2_ff;
   logic                           s3_solid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s3_sq_ff[k] <= SqW'(s2_mag_ff[k]) * SqW'(s2_mag_ff[k]);
         end
         s3_near_ff   <= s2_near_ff;
         s3_mag_ff    <= s2_mag_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_rr_ff     <= s2_rr_ff;
         s3_first_ff  <= s2_first_ff;
         s3_second_ff <= s2_second_ff;
         s3_rsum_ff   <= s2_rsum_ff;
         s3_m1_ff     <= s2_m1_ff;
         s3_m2_ff     <= s2_m2_ff;
         s3_solid_ff  <= s2_solid_ff;
      end
   end

   // Stage 4: squared distance and hit decision.
   logic                           s4_valid_ff;
   logic [SqSumW-1:0]              s4_d2;
   logic                           s4_hit;
   scr_pkg::root_side_type         s4_side_in;
   scr_pkg::root_side_type         s4_side_ff;
   logic [SqW-1:0]                 s4_d2_ff;

   always_comb begin
      s4_d2 = SqSumW'(s3_sq_ff[0]) + SqSumW'(s3_sq_ff[1]) + SqSumW'(s3_sq_ff[2]);
      s4_hit = s3_near_ff && (s4_d2 < SqSumW'(s3_rr_ff));
      s4_side_in.first_pos   = s3_first_ff;
      s4_side_in.second_pos  = s3_second_ff;
      s4_side_in.neg         = s3_neg_ff;
      s4_side_in.mag         = s3_mag_ff;
      s4_side_in.rsum        = s3_rsum_ff;
      s4_side_in.first_mass  = s3_m1_ff;
      s4_side_in.second_mass = s3_m2_ff;
      s4_side_in.hit         = s4_hit;
      s4_side_in.stop        = s4_hit && s3_solid_ff;
      s4_side_in.move        = s4_hit && s3_solid_ff && (s4_d2 != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_side_ff <= s4_side_in;
         s4_d2_ff   <= s4_d2[SqW-1:0];
      end
   end

   // Square root of the squared distance.
   logic                           rt_valid;
   logic [SumW-1:0]                rt_root;
   logic [RootSideW-1:0]           rt_side_raw;
   scr_pkg::root_side_type         rt_side;

   scr_isqrt_pipe #(
      .RootW (SumW),
      .SW    (RootSideW)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (s4_valid_ff),
      .in_radicand (s4_d2_ff),
      .in_side     (s4_side_ff),
      .out_valid   (rt_valid),
      .out_root    (rt_root),
      .out_side    (rt_side_raw)
   );

   assign rt_side = rt_side_raw;

   // Stage 5: overlap, mass products and divider operands.
   logic                           s5_valid_ff;
   logic [SumW-1:0]                s5_overlap;
   logic [2:0][NumW-1:0]           s5_unum_ff;
   logic [DivW-1:0]                s5_dist_ff;
   logic [NumW-1:0]                s5_pnum1_ff;
   logic [NumW-1:0]                s5_pnum2_ff;
   logic [DivW-1:0]                s5_total_ff;
   scr_pkg::quo_side_type          s5_side_in;
   scr_pkg::quo_side_type          s5_side_ff;
   logic [TotW-1:0]                s5_total;

   always_comb begin
      s5_overlap = rt_side.rsum - rt_root;
      s5_total   = TotW'(rt_side.first_mass) + TotW'(rt_side.second_mass);
      s5_side_in.first_pos  = rt_side.first_pos;
      s5_side_in.second_pos = rt_side.second_pos;
      s5_side_in.neg        = rt_side.neg;
      s5_side_in.hit        = rt_side.hit;
      s5_side_in.stop       = rt_side.stop;
      s5_side_in.move       = rt_side.move;
      s5_side_in.zero_total = (s5_total == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= rt_valid;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s5_unum_ff[k] <= NumW'(rt_side.mag[k]) << UnitShift;
         end
         s5_dist_ff  <= rt_root;
         s5_pnum1_ff <= NumW'(ProdW'(s5_overlap) * ProdW'(rt_side.second_mass));
         s5_pnum2_ff <= NumW'(ProdW'(s5_overlap) * ProdW'(rt_side.first_mass));
         s5_total_ff <= DivW'(s5_total);
         s5_side_ff  <= s5_side_in;
      end
   end

   // Unit vector components and mass shares.
   logic [2:0]                     dv_valid;
   logic [2:0][QuoW-1:0]           dv_unit;
   logic [QuoSideW-1:0]            dv_side_raw;
   scr_pkg::quo_side_type          dv_side;
   logic [QuoW-1:0]                dv_push1;
   logic [QuoW-1:0]                dv_push2;

   for (genvar k = 0; k < 3; k++) begin : g_unit
      if (k == 0) begin : g_lead
         scr_div_pipe #(
            .QW (QuoW),
            .DW (DivW),
            .SW (QuoSideW)
         ) u_div (
            .clock        (clock),
            .reset        (reset),
            .adv          (adv),
            .in_valid     (s5_valid_ff),
            .in_dividend  (s5_unum_ff[k]),
            .in_divisor   (s5_dist_ff),
            .in_side      (s5_side_ff),
            .out_valid    (dv_valid[k]),
            .out_quotient (dv_unit[k]),
            .out_side     (dv_side_raw)
         );
      end else begin : g_plain
         scr_div_pipe #(
            .QW (QuoW),
            .DW (DivW),
            .SW (1)
         ) u_div (
            .clock        (clock),
            .reset        (reset),
            .adv          (adv),
            .in_valid     (s5_valid_ff),
            .in_dividend  (s5_unum_ff[k]),
            .in_divisor   (s5_dist_ff),
            .in_side      (1'b0),
            .out_valid    (dv_valid[k]),
            .out_quotient (dv_unit[k]),
            .out_side     ()
         );
      end
   end

   scr_div_pipe #(
      .QW (QuoW),
      .DW (DivW),
      .SW (1)
   ) u_push1 (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (s5_valid_ff),
      .in_dividend  (s5_pnum1_ff),
      .in_divisor   (s5_total_ff),
      .in_side      (1'b0),
      .out_valid    (),
      .out_quotient (dv_push1),
      .out_side     ()
   );

   scr_div_pipe #(
      .QW (QuoW),
      .DW (DivW),
      .SW (1)
   ) u_push2 (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (s5_valid_ff),
      .in_dividend  (s5_pnum2_ff),
      .in_divisor   (s5_total_ff),
      .in_side      (1'b0),
      .out_valid    (),
      .out_quotient (dv_push2),
      .out_side     ()
   );

   assign dv_side = dv_side_raw;

   // Stage 6: per-axis steps.
   logic                           s6_valid_ff;
   logic [SumW-1:0]                s6_push1;
   logic [SumW-1:0]                s6_push2;
   logic [2:0][StepW-1:0]          s6_prod1;
   logic [2:0][StepW-1:0]          s6_prod2;
   logic [2:0][SumW-1:0]           s6_step1_ff;
   logic [2:0][SumW-1:0]           s6_step2_ff;
   scr_pkg::quo_side_type          s6_side_ff;

   always_comb begin
      s6_push1 = dv_side.zero_total ? '0 : dv_push1[SumW-1:0];
      s6_push2 = dv_side.zero_total ? '0 : dv_push2[SumW-1:0];
      for (int k = 0; k < 3; k++) begin
         s6_prod1[k] = StepW'(dv_unit[k]) * StepW'(s6_push1);
         s6_prod2[k] = StepW'(dv_unit[k]) * StepW'(s6_push2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= dv_valid[0];
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s6_step1_ff[k] <= s6_prod1[k][UnitShift +: SumW];
            s6_step2_ff[k] <= s6_prod2[k][UnitShift +: SumW];
         end
         s6_side_ff <= dv_side;
      end
   end

   // Output register: apply steps with saturation.
   scr_pkg::pos_type [2:0]         out_first_in;
   scr_pkg::pos_type [2:0]         out_second_in;
   scr_pkg::pos_type [2:0]         out_first_ff;
   scr_pkg::pos_type [2:0]         out_second_ff;
   logic                           out_hit_ff;
   logic                           out_stop_ff;
   logic signed [WideW-1:0]        o_base1;
   logic signed [WideW-1:0]        o_base2;
   logic signed [WideW-1:0]        o_step1;
   logic signed [WideW-1:0]        o_step2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         o_base1 = WideW'(s6_side_ff.first_pos[k]);
         o_base2 = WideW'(s6_side_ff.second_pos[k]);
         o_step1 = WideW'(s6_step1_ff[k]);
         o_step2 = WideW'(s6_step2_ff[k]);
         if (!s6_side_ff.move) begin
            out_first_in[k]  = s6_side_ff.first_pos[k];
            out_second_in[k] = s6_side_ff.second_pos[k];
         end else if (s6_side_ff.neg[k]) begin
            out_first_in[k]  = scr_pkg::sat_pos(o_base1 - o_step1);
            out_second_in[k] = scr_pkg::sat_pos(o_base2 + o_step2);
         end else begin
            out_first_in[k]  = scr_pkg::sat_pos(o_base1 + o_step1);
            out_second_in[k] = scr_pkg::sat_pos(o_base2 - o_step2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s6_valid_ff;
      end
      if (adv) begin
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_hit_ff    <= s6_side_ff.hit;
         out_stop_ff   <= s6_side_ff.stop;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_stop_both    = out_stop_ff;
   assign rsp_new_first_x  = out_first_ff[0];
   assign rsp_new_first_y  = out_first_ff[1];
   assign rsp_new_first_z  = out_first_ff[2];
   assign rsp_new_second_x = out_second_ff[0];
   assign rsp_new_second_y = out_second_ff[1];
   assign rsp_new_second_z = out_second_ff[2];

   // A stop request always comes with a hit.
   a_stop_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_both |-> rsp_hit)
      else $error("stop_both without hit");

   // A moving pair has a nonzero squared distance, so its root is at least one.
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      rt_valid && rt_side.move |-> rt_root != '0)
      else $error("zero root on a moving pair");

   // Unit components never exceed one in Q1.30.
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] && dv_side.move |->
         (dv_unit[0] <= (QuoW'(1) << UnitShift)) &&
         (dv_unit[1] <= (QuoW'(1) << UnitShift)) &&
         (dv_unit[2] <= (QuoW'(1) << UnitShift)))
      else $error("unit component out of range");

   // All three unit-vector lanes of the divider bank stay in step.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] == dv_valid[1] && dv_valid[0] == dv_valid[2])
      else $error("divider lanes out of step");

endmodule
`default_nettype wire

[tb/tb_sphere_collision_resolve_top.sv]
// Testbench for sphere_collision_resolve_top: directed table of body pairs, then
// random pairs, each result checked against a behavioral collision predictor.
// Depends on rtl/scr_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps
module tb_sphere_collision_resolve_top;

   typedef struct {
      logic signed [31:0] p1 [3];
      logic signed [31:0] p2 [3];
      logic [23:0] r1, r2;
      logic [15:0] m1, m2;
      logic [1:0] f1, f2;
   } pair_type;

   typedef struct {
      logic hit, stop;
      logic signed [31:0] n1 [3];
      logic signed [31:0] n2 [3];
   } outcome_type;

   typedef struct {
      pair_type pr;
      logic known;
      logic hit, stop;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_first_x = 0, req_first_y = 0, req_first_z = 0;
   logic signed [31:0] req_second_x = 0, req_second_y = 0, req_second_z = 0;
   logic [23:0] req_first_radius = 0, req_second_radius = 0;
   logic [15:0] req_first_mass = 1, req_second_mass = 1;
   logic [1:0] req_first_flags = 0, req_second_flags = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_hit, rsp_stop_both;
   logic signed [31:0] rsp_new_first_x, rsp_new_first_y, rsp_new_first_z;
   logic signed [31:0] rsp_new_second_x, rsp_new_second_y, rsp_new_second_z;

   outcome_type expected_q [$];
   int errors = 0;
   int cycles = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;

   always #4 clock = ~clock;

   sphere_collision_resolve_top i_dut (.*);

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic outcome_type resolve_pair(input pair_type pr);
      outcome_type o;
      longint d [3];
      longint n1 [3], n2 [3];
      logic [63:0] ad [3];
      logic [63:0] r, d2, root_d, overlap, total, push1, push2, u, s1, s2;
      r = pr.r1 + pr.r2;
      d2 = 0;
      o.hit = 0;
      o.stop = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'(pr.p1[i]) - longint'(pr.p2[i]);
         ad[i] = d[i] < 0 ? -d[i] : d[i];
         n1[i] = pr.p1[i];
         n2[i] = pr.p2[i];
      end
      if (pr.f1[0] && pr.f2[0] && ad[0] < r && ad[1] < r && ad[2] < r) begin
         d2 = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
         o.hit = d2 < r * r;
      end
      if (o.hit && pr.f1[1] && pr.f2[1]) begin
         o.stop = 1;
         if (d2 > 0) begin
            root_d = root_floor(d2);
            overlap = r - root_d;
            total = pr.m1 + pr.m2;
            push1 = 0;
            push2 = 0;
            if (total != 0) begin
               push1 = overlap * pr.m2 / total;
               push2 = overlap * pr.m1 / total;
            end
            for (int i = 0; i < 3; i++) begin
               u = (ad[i] << 30) / root_d;
               s1 = (u * push1) >> 30;
               s2 = (u * push2) >> 30;
               if (d[i] < 0) begin
                  n1[i] = n1[i] - longint'(s1);
                  n2[i] = n2[i] + longint'(s2);
               end else begin
                  n1[i] = n1[i] + longint'(s1);
                  n2[i] = n2[i] - longint'(s2);
               end
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         o.n1[i] = clamp32(n1[i]);
         o.n2[i] = clamp32(n2[i]);
      end
      return o;
   endfunction

   function automatic pair_type make_pair(input logic signed [31:0] x1, y1, z1, x2, y2, z2,
                                          input logic [23:0] r1, r2,
                                          input logic [15:0] m1, m2,
                                          input logic [1:0] f1, f2);
      pair_type p;
      p.p1[0] = x1; p.p1[1] = y1; p.p1[2] = z1;
      p.p2[0] = x2; p.p2[1] = y2; p.p2[2] = z2;
      p.r1 = r1; p.r2 = r2; p.m1 = m1; p.m2 = m2; p.f1 = f1; p.f2 = f2;
      return p;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int mode;
      logic [23:0] span;
      mode = $urandom_range(0, 9);
      p.r1 = 24'($urandom);
      p.r2 = 24'($urandom);
      if (mode < 6) begin
         p.r1 = $urandom_range(0, 1) ? 24'($urandom_range(1, 24'h3ffff)) : 24'($urandom);
         p.r2 = $urandom_range(0, 1) ? 24'($urandom_range(1, 24'h3ffff)) : 24'($urandom);
         span = 24'((p.r1 >> 1) + (p.r2 >> 1) + 1);
         for (int i = 0; i < 3; i++) begin
            p.p1[i] = $urandom;
            if (mode == 5) p.p1[i] = $urandom_range(0, 1) ? 32'sh7fff0000 : 32'sh80010000;
            p.p2[i] = p.p1[i] + $signed(32'($urandom_range(0, 2 * span))) - $signed({8'b0, span});
         end
         p.f1 = $urandom_range(0, 9) < 8 ? 2'b11 : 2'($urandom);
         p.f2 = $urandom_range(0, 9) < 8 ? 2'b11 : 2'($urandom);
      end else begin
         for (int i = 0; i < 3; i++) begin
            p.p1[i] = $urandom;
            p.p2[i] = $urandom_range(0, 1) ? $urandom : p.p1[i] ^ 32'($urandom_range(0, 255));
         end
         p.f1 = 2'($urandom);
         p.f2 = 2'($urandom);
      end
      p.m1 = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 65535));
      p.m2 = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 65535));
      return p;
   endfunction

   task automatic send_pair(input pair_type p);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_first_x <= p.p1[0]; req_first_y <= p.p1[1]; req_first_z <= p.p1[2];
      req_second_x <= p.p2[0]; req_second_y <= p.p2[1]; req_second_z <= p.p2[2];
      req_first_radius <= p.r1; req_second_radius <= p.r2;
      req_first_mass <= p.m1; req_second_mass <= p.m2;
      req_first_flags <= p.f1; req_second_flags <= p.f2;
      expected_q.push_back(resolve_pair(p));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want, got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type e;
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t mismatch: unexpected word, expected none actual hit=%0b",
                     $time, rsp_hit);
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("hit", 32'(e.hit), 32'(rsp_hit));
            check_field("stop_both", 32'(e.stop), 32'(rsp_stop_both));
            check_field("new_first_x", e.n1[0], rsp_new_first_x);
            check_field("new_first_y", e.n1[1], rsp_new_first_y);
            check_field("new_first_z", e.n1[2], rsp_new_first_z);
            check_field("new_second_x", e.n2[0], rsp_new_second_x);
            check_field("new_second_y", e.n2[1], rsp_new_second_y);
            check_field("new_second_z", e.n2[2], rsp_new_second_z);
         end
      end
   end

   initial begin
      int wait_n;
      wait_n = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         wait_n = $urandom_range(0, 16);
         if ($urandom_range(0, 3) == 0) wait_n = 0;
         if (wait_n != 0) begin
            rsp_ready <= 0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   initial begin
      row_type rows [$];
      row_type rw;
      outcome_type got;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      rw.known = 1;
      rw.hit = 0; rw.stop = 0;
      rw.pr = make_pair(0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        0, 0, 1, 1, 3, 3);
      rows.push_back(rw);
      rw.pr = make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        24'hffffff, 24'hffffff, 16'hffff, 16'hffff, 3, 3);
      rows.push_back(rw);
      rw.pr = make_pair(0, 0, 0, 32'h10000, 0, 0, 24'h10000, 24'h10000, 1, 1, 2, 3);
      rows.push_back(rw);
      rw.hit = 1;
      rw.pr = make_pair(0, 0, 0, 32'h10000, 0, 0, 24'h10000, 24'h10000, 1, 1, 1, 3);
      rows.push_back(rw);
      rw.stop = 1;
      rw.pr = make_pair(5, 6, 7, 5, 6, 7, 24'h10, 24'h10, 3, 9, 3, 3);
      rows.push_back(rw);
      rw.hit = 0; rw.stop = 0;
      rw.pr = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 3, 3);
      rows.push_back(rw);
      rw.known = 0;
      rows.push_back('{make_pair(0, 0, 0, 32'h8000, 32'h8000, 0, 24'h10000, 24'h10000,
                                1, 1, 3, 3), 0, 0, 0});
      rows.push_back('{make_pair(32'sh7fff8000, 0, 0, 32'sh7fff0000, 0, 0, 24'hffffff,
                                24'hffffff, 1, 16'hffff, 3, 3), 0, 0, 0});
      rows.push_back('{make_pair(32'sh80008000, -1, 1, 32'sh80010000, 1, -1, 24'hffffff,
                                24'hffffff, 16'hffff, 1, 3, 3), 0, 0, 0});
      rows.push_back('{make_pair(100, -200, 300, -100, 200, -300, 24'h1, 24'hffffff,
                                16'hffff, 16'hffff, 3, 3), 0, 0, 0});
      rows.push_back('{make_pair(0, 0, 0, 1, 0, 0, 1, 1, 1, 1, 3, 3), 0, 0, 0});
      foreach (rows[k]) begin
         if (rows[k].known) begin
            got = resolve_pair(rows[k].pr);
            if (got.hit !== rows[k].hit || got.stop !== rows[k].stop) begin
               $display("%0t mismatch table row %0d: expected %0b%0b actual %0b%0b",
                        $time, k, rows[k].hit, rows[k].stop, got.hit, got.stop);
               errors++;
            end
         end
         send_pair(rows[k].pr);
      end
      for (int n = 0; n < 1150; n++) begin
         if (n == 300) hold_rsp = 1;
         if (n == 700) begin
            req_valid <= 0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         send_pair(random_pair());
      end
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
